/* rtl/b64sd_pkg.sv */
// Shared types, constants and the alphabet decode for the base64 decoder.
`timescale 1ns / 1ps

package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Work for the output side: one to three bytes, or one error transaction.
  typedef struct packed {
    logic [23:0] bytes;  // first byte in [23:16]
    logic [1:0]  cnt;    // number of bytes, 1..3
    logic        err;
    logic        fin;    // last byte of the packet closes the text
  } b64sd_pkt_t;

  // Bit 6 set: character is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = 7'd62;
    else if (c == 8'h2F) r = 7'd63;
    return r;
  endfunction

endpackage

/* rtl/base64_strict_decoder_top.sv */
// A completed group or an error passes the packet queue, pkt_r and the output register.
// Throughput: one character per cycle unless in_full; the output register drains one byte
// per cycle while popped; the four-entry queue lets intake run on while output stalls.
// Reset (rst_n low, synchronous) clears group state, the queue and the output register.
// Top level of the strict base64 decoder.
`timescale 1ns / 1ps

module base64_strict_decoder_top
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_code_char,
  input  logic       in_final_char,
  input  logic       in_push,
  output logic       in_full,
  output logic [7:0] out_data_byte,
  output logic       out_error,
  output logic       out_final_byte,
  output logic       out_empty,
  input  logic       out_pop
);

  b64sd_pkt_t  f_pkt, q_pkt;
  logic        f_push, q_pop, q_full, q_empty;

  assign in_full = q_full;

  b64sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_push && !q_full),
    .code_char  (in_code_char),
    .final_char (in_final_char),
    .pkt_push   (f_push),
    .pkt        (f_pkt)
  );

  b64sd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_pkt),
    .pop   (q_pop),
    .rdata (q_pkt),
    .full  (q_full),
    .empty (q_empty)
  );

  b64sd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_pkt),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .data_byte  (out_data_byte),
    .error      (out_error),
    .final_byte (out_final_byte),
    .empty      (out_empty),
    .pop        (out_pop)
  );

endmodule

/* rtl/b64sd_front.sv */
// Character intake: classifies characters, collects groups, flags errors.
`timescale 1ns / 1ps

module b64sd_front
  import b64sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  code_char,
  input  logic        final_char,
  output logic        pkt_push,
  output b64sd_pkt_t  pkt
);

  logic [17:0] bits_r, bits_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  pads_r, pads_nxt;
  logic        drop_r, drop_nxt;

  logic [6:0]  sx;
  logic        is_pad;
  logic [5:0]  v;
  logic [23:0] bits;
  logic [1:0]  pads;
  logic        err;

  always_comb begin
    sx     = sextet_of(code_char);
    is_pad = (code_char == PAD_CHAR);
    v      = is_pad ? 6'd0 : sx[5:0];
    err    = 1'b0;
    if (is_pad) begin
      if (pos_r < 2'd2) err = 1'b1;
      if (pos_r == 2'd3 && !final_char) err = 1'b1;
    end else begin
      if (sx[6]) err = 1'b1;
      if (pads_r != 2'd0) err = 1'b1;
    end
    if (final_char && pos_r != 2'd3) err = 1'b1;
    bits = {bits_r, v};
    pads = pads_r + {1'b0, is_pad};
    // leftover bits under padding must be zero
    if (pos_r == 2'd3) begin
      if (pads == 2'd1 && bits[7:0] != 8'd0) err = 1'b1;
      if (pads == 2'd2 && bits[15:0] != 16'd0) err = 1'b1;
    end

    bits_nxt = bits_r;
    pos_nxt  = pos_r;
    pads_nxt = pads_r;
    drop_nxt = drop_r;
    pkt_push = 1'b0;
    pkt      = '{bytes: bits, cnt: 2'(3 - pads), err: 1'b0, fin: final_char};

    if (accept) begin
      if (drop_r) begin
        if (final_char) begin
          drop_nxt = 1'b0;
          bits_nxt = '0;
          pos_nxt  = '0;
          pads_nxt = '0;
        end
      end else if (err) begin
        pkt_push = 1'b1;
        pkt      = '{bytes: 24'd0, cnt: 2'd1, err: 1'b1, fin: 1'b1};
        drop_nxt = !final_char;
        bits_nxt = '0;
        pos_nxt  = '0;
        pads_nxt = '0;
      end else if (pos_r == 2'd3) begin
        pkt_push = 1'b1;
        bits_nxt = '0;
        pos_nxt  = '0;
        pads_nxt = '0;
      end else begin
        bits_nxt = bits[17:0];
        pos_nxt  = pos_r + 2'd1;
        pads_nxt = pads;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      pos_r  <= '0;
      pads_r <= '0;
      drop_r <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      pos_r  <= pos_nxt;
      pads_r <= pads_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

/* rtl/b64sd_queue.sv */
// Short packet queue between the character intake and the byte output side.
`timescale 1ns / 1ps

module b64sd_queue
  import b64sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64sd_pkt_t  wdata,
  input  logic        pop,
  output b64sd_pkt_t  rdata,
  output logic        full,
  output logic        empty
);

  b64sd_pkt_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_r, rptr_r;
  logic [QUEUE_AW:0]    cnt_r;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end
  end

endmodule

/* rtl/b64sd_back.sv */
// Byte output side: unpacks queued packets into one byte per transaction.
`timescale 1ns / 1ps

module b64sd_back
  import b64sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  b64sd_pkt_t  q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic [7:0]  data_byte,
  output logic        error,
  output logic        final_byte,
  output logic        empty,
  input  logic        pop
);

  b64sd_pkt_t  pkt_r;
  logic        pkt_vld_r;
  logic [1:0]  idx_r;
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic        out_err_r, out_fin_r;

  logic        can_load, emit, last, take;
  logic [7:0]  sel_byte;

  always_comb begin
    can_load = !out_vld_r || pop;
    emit     = pkt_vld_r && can_load;
    last     = (idx_r + 2'd1) == pkt_r.cnt;
    take     = !pkt_vld_r || (emit && last);
    q_pop    = take && !q_empty;
    case (idx_r)
      2'd0:    sel_byte = pkt_r.bytes[23:16];
      2'd1:    sel_byte = pkt_r.bytes[15:8];
      default: sel_byte = pkt_r.bytes[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      // advance within the packet, or fetch the next one
      if (take) begin
        pkt_vld_r <= !q_empty;
        idx_r     <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
      if (emit)     out_vld_r <= 1'b1;
      else if (pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) pkt_r <= q_data;
    if (emit) begin
      out_byte_r <= sel_byte;
      out_err_r  <= pkt_r.err;
      out_fin_r  <= pkt_r.fin && last;
    end
  end

  assign data_byte  = out_byte_r;
  assign error      = out_err_r;
  assign final_byte = out_fin_r;
  assign empty      = !out_vld_r;

endmodule
